FILE: sv/lswap_pkg.sv
// lswap_pkg: types, codes and defaults shared by the end-swap stack modules
// no dependencies; imported by lswap_ram, lswap_ctrl and lifo_stack_with_end_swap

package lswap_pkg;

  // default geometry of the stack store
  localparam int unsigned DEPTH_DEF      = 128;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // fixed widths of the transaction fields
  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SWAP = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // read value on pop or peek of an empty stack, and for push and swap
  localparam logic signed [VALUE_W-1:0] READ_EMPTY = '1;
  localparam logic signed [VALUE_W-1:0] READ_NONE  = '0;

  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    status_e                   status;
    logic                      is_empty;
    logic [COUNT_W-1:0]        entry_count;
  } out_item_t;

  // single-port memory command
  typedef struct packed {
    logic en;
    logic we;
  } mem_cmd_t;

endpackage

FILE: sv/lswap_ram.sv
// lswap_ram: single-port synchronous stack store with a registered read port
// depends on lswap_pkg for the memory command struct

module lswap_ram #(
  parameter int unsigned Depth     = lswap_pkg::DEPTH_DEF,
  parameter int unsigned DataWidth = lswap_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  lswap_pkg::mem_cmd_t      cmd_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [DataWidth-1:0]     wdata_i,
  output logic [DataWidth-1:0]     rdata_o
);
  import lswap_pkg::*;

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      if (cmd_i.we) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/lswap_ctrl.sv
// lswap_ctrl: operation sequencer, fill count and result register of the stack
// depends on lswap_pkg; drives the port of lswap_ram

module lswap_ctrl #(
  parameter int unsigned Depth     = lswap_pkg::DEPTH_DEF,
  parameter int unsigned DataWidth = lswap_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  lswap_pkg::in_item_t      in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output lswap_pkg::out_item_t     out_item_o,
  output lswap_pkg::mem_cmd_t      mem_cmd_o,
  output logic [$clog2(Depth)-1:0] mem_addr_o,
  output logic [DataWidth-1:0]     mem_wdata_o,
  input  logic [DataWidth-1:0]     mem_rdata_i
);
  import lswap_pkg::*;

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_READ    = 3'd1;
  localparam logic [2:0] S_SWAP_B  = 3'd2;
  localparam logic [2:0] S_SWAP_WT = 3'd3;
  localparam logic [2:0] S_SWAP_WB = 3'd4;
  localparam logic [2:0] S_HOLD    = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [CntW-1:0]           count_q, count_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_item_q, out_item_d;
  out_item_t                 hold_q, hold_d;
  logic [DataWidth-1:0]      top_q, top_d;
  logic                      accept;
  logic                      out_free;
  logic                      fin;
  out_item_t                 fin_item;
  logic                      is_empty_now;
  logic                      is_full_now;
  logic [AddrW-1:0]          top_addr;
  logic signed [VALUE_W-1:0] rd_word;

  function automatic out_item_t make_res(logic signed [VALUE_W-1:0] value,
                                         status_e st, logic [CntW-1:0] cnt);
    out_item_t res;
    res.read_value  = value;
    res.status      = st;
    res.is_empty    = (cnt == '0);
    res.entry_count = COUNT_W'(cnt);
    return res;
  endfunction

  assign in_stall_o   = (state_q != S_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign is_empty_now = (count_q == '0);
  assign is_full_now  = (count_q == CntW'(Depth));
  assign top_addr     = AddrW'(count_q - CntW'(1));
  // sign-extend or truncate the stored word to the result width
  assign rd_word      = VALUE_W'($signed(mem_rdata_i));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    top_d       = top_q;
    hold_d      = hold_q;
    mem_cmd_o   = '0;
    mem_addr_o  = top_addr;
    mem_wdata_o = mem_rdata_i;
    fin         = 1'b0;
    fin_item    = hold_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item_i.op)
            OP_PUSH: begin
              fin = 1'b1;
              if (is_full_now) begin
                fin_item = make_res(READ_NONE, STATUS_FULL, count_q);
              end else begin
                mem_cmd_o   = '{en: 1'b1, we: 1'b1};
                mem_addr_o  = AddrW'(count_q);
                mem_wdata_o = DataWidth'($unsigned(in_item_i.push_value));
                count_d     = count_q + CntW'(1);
                fin_item    = make_res(READ_NONE, STATUS_OK, count_d);
              end
            end
            OP_POP, OP_PEEK: begin
              if (is_empty_now) begin
                fin      = 1'b1;
                fin_item = make_res(READ_EMPTY, STATUS_EMPTY, count_q);
              end else begin
                mem_cmd_o = '{en: 1'b1, we: 1'b0};
                if (in_item_i.op == OP_POP) begin
                  count_d = count_q - CntW'(1);
                end
                state_d = S_READ;
              end
            end
            OP_SWAP: begin
              if (is_empty_now) begin
                fin      = 1'b1;
                fin_item = make_res(READ_NONE, STATUS_EMPTY, count_q);
              end else begin
                mem_cmd_o = '{en: 1'b1, we: 1'b0};
                state_d   = S_SWAP_B;
              end
            end
          endcase
        end
      end
      S_READ: begin
        fin      = 1'b1;
        fin_item = make_res(rd_word, STATUS_OK, count_q);
        state_d  = S_IDLE;
      end
      S_SWAP_B: begin
        // top word arrives, fetch the bottom
        top_d      = mem_rdata_i;
        mem_cmd_o  = '{en: 1'b1, we: 1'b0};
        mem_addr_o = '0;
        state_d    = S_SWAP_WT;
      end
      S_SWAP_WT: begin
        mem_cmd_o = '{en: 1'b1, we: 1'b1};
        state_d   = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        mem_cmd_o   = '{en: 1'b1, we: 1'b1};
        mem_addr_o  = '0;
        mem_wdata_o = top_q;
        fin         = 1'b1;
        fin_item    = make_res(READ_NONE, STATUS_OK, count_q);
        state_d     = S_IDLE;
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin && !out_free) begin
      hold_d  = fin_item;
      state_d = S_HOLD;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (fin && out_free) begin
      out_valid_d = 1'b1;
      out_item_d  = fin_item;
    end else if (state_q == S_HOLD && out_free) begin
      out_valid_d = 1'b1;
      out_item_d  = hold_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    hold_q     <= hold_d;
    top_q      <= top_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: sv/lifo_stack_with_end_swap.sv
// lifo_stack_with_end_swap: top level of the signed-word stack with top/bottom swap
// depends on lswap_pkg, lswap_ram and lswap_ctrl
//
//   channel   dir   handshake               payload
//   in        in    in_valid_i / in_stall_o   in_item_i  (op, push_value)
//   out       out   out_valid_o / out_stall_i out_item_o (read_value, status,
//                                                        is_empty, entry_count)
//
// one transaction at a time; push and every empty or full case finish in the
// accepting state, pop and peek wait for the memory read, swap does two reads
// and two writes on the single memory port
// the result sits in an output register; a stalled result blocks the input
// only once the next result is ready, which then waits in a hold register
// reset clears the fill count and the sequencer only; the store needs no
// clearing pass since no entry is read before it is written

module lifo_stack_with_end_swap #(
  parameter int unsigned Depth     = lswap_pkg::DEPTH_DEF,
  parameter int unsigned DataWidth = lswap_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lswap_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lswap_pkg::out_item_t out_item_o
);
  import lswap_pkg::*;

  localparam int unsigned AddrW = $clog2(Depth);

  // single memory port between sequencer and store
  mem_cmd_t             mem_cmd;
  logic [AddrW-1:0]     mem_addr;
  logic [DataWidth-1:0] mem_wdata;
  logic [DataWidth-1:0] mem_rdata;

  // sequencer: decodes the operation, keeps the fill count, owns the result
  lswap_ctrl #(
    .Depth     (Depth),
    .DataWidth (DataWidth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .mem_cmd_o   (mem_cmd),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  // stack store, entry 0 is the bottom
  lswap_ram #(
    .Depth     (Depth),
    .DataWidth (DataWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: bench/lifo_stack_with_end_swap_test.sv
// lifo_stack_with_end_swap_test: self-checking bench for the end-swap stack
// drives operations over the valid/stall input channel, predicts every result
// depends on lswap_pkg and lifo_stack_with_end_swap
`timescale 1ns / 100ps

module lifo_stack_with_end_swap_test;
  import lswap_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 450;
  // the slowest transaction is a swap behind a blocking stall run and a sender
  // gap, so this limit allows for it many times over
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned PRINT_LIMIT  = 30;

  localparam logic signed [VALUE_W-1:0] WORD_MAX   = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] WORD_MIN   = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] WORD_ZERO  = 32'sh0000_0000;
  localparam logic signed [VALUE_W-1:0] WORD_ONES  = 32'shffff_ffff;
  // value carried by non-push transactions, must not matter
  localparam logic signed [VALUE_W-1:0] WORD_JUNK  = 32'sh5a3c_c3a5;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_SPARSE,
    STALL_ALTERNATE,
    STALL_BLOCKS
  } stall_mode_e;

  // one row of the directed table; want is only used when typed is set
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // bench copy of the stack
  logic [VALUE_W-1:0] stack_words [DEPTH];
  int unsigned        stack_fill;

  out_item_t   awaited_results [$];
  stim_row_t   directed_rows [$];

  int unsigned ops_sent;
  int unsigned results_seen;
  int unsigned errors;
  int unsigned full_refusals;
  int unsigned empty_hits;
  int unsigned swaps_done;
  int unsigned peak_fill;
  int unsigned burst_left;
  int unsigned idle_cycles;

  lifo_stack_with_end_swap i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // applies one accepted operation to the bench stack and returns its result
  function automatic out_item_t apply_stack_op(input in_item_t it);
    out_item_t          r;
    logic [VALUE_W-1:0] top;
    r.read_value = READ_NONE;
    r.status     = STATUS_OK;
    case (it.op)
      OP_PUSH: begin
        if (stack_fill >= DEPTH) begin
          r.status = STATUS_FULL;
          full_refusals++;
        end else begin
          stack_words[stack_fill] = it.push_value;
          stack_fill++;
        end
      end
      OP_POP: begin
        if (stack_fill == 0) begin
          r.status     = STATUS_EMPTY;
          r.read_value = READ_EMPTY;
        end else begin
          stack_fill--;
          r.read_value = stack_words[stack_fill];
        end
      end
      OP_PEEK: begin
        if (stack_fill == 0) begin
          r.status     = STATUS_EMPTY;
          r.read_value = READ_EMPTY;
        end else begin
          r.read_value = stack_words[stack_fill-1];
        end
      end
      OP_SWAP: begin
        if (stack_fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          // with one entry this exchanges the entry with itself
          top                       = stack_words[stack_fill-1];
          stack_words[stack_fill-1] = stack_words[0];
          stack_words[0]            = top;
          swaps_done++;
        end
      end
      default: ;
    endcase
    if (r.status == STATUS_EMPTY) empty_hits++;
    if (stack_fill > peak_fill) peak_fill = stack_fill;
    r.is_empty    = (stack_fill == 0);
    r.entry_count = stack_fill[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void add_row(input op_e op, input logic signed [VALUE_W-1:0] value,
                                  input bit typed = 1'b0,
                                  input logic signed [VALUE_W-1:0] rv = '0,
                                  input status_e st = STATUS_OK,
                                  input logic emp = 1'b0,
                                  input logic [COUNT_W-1:0] cnt = '0);
    stim_row_t row;
    row.item.op               = op;
    row.item.push_value       = value;
    row.typed                 = typed;
    row.want.read_value       = rv;
    row.want.status           = st;
    row.want.is_empty         = emp;
    row.want.entry_count      = cnt;
    directed_rows.push_back(row);
  endfunction

  // mostly full-range words, with the extremes mixed in
  function automatic logic signed [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return WORD_ZERO;
      3:       return WORD_ONES;
      default: return $urandom;
    endcase
  endfunction

  // bias_op with probability pct per cent, otherwise any operation
  function automatic op_e pick_op(input op_e bias_op, input int unsigned pct);
    if ($urandom_range(0, 99) < pct) return bias_op;
    return op_e'($urandom_range(0, 3));
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_LIMIT) $display("mismatch: %s", msg);
    errors++;
  endtask

  // offers one transaction on the input channel, in bursts with random gaps,
  // and records what it should produce once the block takes it
  task automatic drive_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   predicted;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    // held until taken at a rising edge
    do @(posedge clk); while (!(in_valid && !in_stall));
    predicted = apply_stack_op(it);
    awaited_results.push_back(typed ? want : predicted);
    ops_sent++;
  endtask

  task automatic send_random(input op_e op);
    in_item_t it;
    it.op         = op;
    it.push_value = rand_word();
    drive_item(it, 1'b0, '0);
  endtask

  // result side: every accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t exp;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        exp = awaited_results.pop_front();
        if (out_item.read_value !== exp.read_value)
          report_mismatch($sformatf("result %0d read_value %0h, expected %0h",
                                    results_seen, out_item.read_value, exp.read_value));
        if (out_item.status !== exp.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    results_seen, out_item.status, exp.status));
        if (out_item.is_empty !== exp.is_empty)
          report_mismatch($sformatf("result %0d is_empty %0b, expected %0b",
                                    results_seen, out_item.is_empty, exp.is_empty));
        if (out_item.entry_count !== exp.entry_count)
          report_mismatch($sformatf("result %0d entry_count %0d, expected %0d",
                                    results_seen, out_item.entry_count, exp.entry_count));
      end
    end
  end

  // watchdog: cycles in which neither channel moves a transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: %0d cycles without a transaction, %0d results pending",
                   idle_cycles, awaited_results.size());
          $display("lifo_stack_with_end_swap verification failed");
          $finish;
        end
      end
    end
  end

  // receiver stall pattern: modes of random length, including no stall at all
  initial begin : stall_pattern
    stall_mode_e mode;
    int unsigned left;
    int unsigned run;
    out_stall = 1'b0;
    @(posedge rst_n);
    run = 0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      left = $urandom_range(40, 120);
      while (left > 0) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:      out_stall <= 1'b0;
          STALL_SPARSE:    out_stall <= ($urandom_range(0, 3) == 0);
          STALL_ALTERNATE: out_stall <= ~out_stall;
          STALL_BLOCKS: begin
            if (run == 0) begin
              if (out_stall) begin
                out_stall <= 1'b0;
                run = $urandom_range(1, 4);
              end else begin
                out_stall <= 1'b1;
                run = $urandom_range(3, 15);
              end
            end
            run--;
          end
          default: out_stall <= 1'b0;
        endcase
        left--;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_no;
    int unsigned directed_count;
    in_valid    = 1'b0;
    in_item     = '0;
    rst_n       = 1'b0;
    stack_fill  = 0;
    ops_sent    = 0;
    results_seen = 0;
    errors      = 0;
    full_refusals = 0;
    empty_hits  = 0;
    swaps_done  = 0;
    peak_fill   = 0;
    burst_left  = 0;
    idle_cycles = 0;
    phase_no    = 0;

    // directed table: empty cases after reset, one-entry swap, word extremes
    add_row(OP_POP,  WORD_JUNK, 1'b1, READ_EMPTY, STATUS_EMPTY, 1'b1, 8'd0);
    add_row(OP_PEEK, WORD_JUNK, 1'b1, READ_EMPTY, STATUS_EMPTY, 1'b1, 8'd0);
    add_row(OP_SWAP, WORD_JUNK, 1'b1, READ_NONE,  STATUS_EMPTY, 1'b1, 8'd0);
    add_row(OP_PUSH, WORD_MAX,  1'b1, READ_NONE,  STATUS_OK,    1'b0, 8'd1);
    add_row(OP_PEEK, WORD_JUNK, 1'b1, WORD_MAX,   STATUS_OK,    1'b0, 8'd1);
    add_row(OP_SWAP, WORD_JUNK, 1'b1, READ_NONE,  STATUS_OK,    1'b0, 8'd1);
    add_row(OP_PEEK, WORD_JUNK, 1'b1, WORD_MAX,   STATUS_OK,    1'b0, 8'd1);
    add_row(OP_PUSH, WORD_MIN,  1'b1, READ_NONE,  STATUS_OK,    1'b0, 8'd2);
    add_row(OP_SWAP, WORD_JUNK);
    add_row(OP_PEEK, WORD_JUNK);
    add_row(OP_PUSH, WORD_ZERO, 1'b1, READ_NONE,  STATUS_OK,    1'b0, 8'd3);
    add_row(OP_PUSH, WORD_ONES, 1'b1, READ_NONE,  STATUS_OK,    1'b0, 8'd4);
    add_row(OP_PUSH, 32'sh5555_5555);
    add_row(OP_PUSH, 32'shaaaa_aaaa);
    add_row(OP_SWAP, WORD_JUNK);
    add_row(OP_POP,  WORD_JUNK);
    add_row(OP_PEEK, WORD_JUNK);
    add_row(OP_POP,  WORD_JUNK);
    add_row(OP_POP,  WORD_JUNK);
    add_row(OP_POP,  WORD_JUNK);
    add_row(OP_POP,  WORD_JUNK);
    add_row(OP_SWAP, WORD_JUNK);
    add_row(OP_POP,  WORD_JUNK);
    add_row(OP_POP,  WORD_JUNK, 1'b1, READ_EMPTY, STATUS_EMPTY, 1'b1, 8'd0);
    directed_count = directed_rows.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // random part: mixed noise alternating with fill-to-full and drain-to-empty
    // runs, so that full refusals and the one-entry and empty edges come up
    while (ops_sent - directed_count < RANDOM_ITEMS) begin
      case (phase_no % 4)
        1: begin
          while (stack_fill < DEPTH && ops_sent - directed_count < RANDOM_ITEMS)
            send_random(pick_op(OP_PUSH, 85));
          repeat (4) send_random(pick_op(OP_PUSH, 85));
        end
        3: begin
          while (stack_fill > 0 && ops_sent - directed_count < RANDOM_ITEMS)
            send_random(pick_op(OP_POP, 80));
          repeat (4) send_random(pick_op(OP_POP, 50));
        end
        default: begin
          repeat (30) send_random(pick_op(OP_PUSH, 0));
        end
      endcase
      phase_no++;
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain outstanding results, then a short tail for anything spurious
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d operations sent, %0d results compared, %0d mismatches",
             ops_sent, results_seen, errors);
    $display("peak fill %0d of %0d, %0d full refusals, %0d empty-status results, %0d swaps",
             peak_fill, DEPTH, full_refusals, empty_hits, swaps_done);
    if (errors == 0) begin
      $display("lifo_stack_with_end_swap verification clean");
    end else begin
      $display("lifo_stack_with_end_swap verification failed");
    end
    $finish;
  end

endmodule
